/* hw/rtl/prq_pkg.sv */
`timescale 1ns / 1ps
// Package for the pending request queue: sizes, codes, entry type, helpers.
// Used by prq_csr and the core; depends on nothing.
package prq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_W = PTR_W + 1;

   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PENDING = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AGE_CUTOFF = 2'd1;

   localparam logic [1:0] CMD_ADD = 2'd0;
   localparam logic [1:0] CMD_TAKE = 2'd1;
   localparam logic [1:0] CMD_REMOVE = 2'd2;

   localparam logic [2:0] ST_ACCEPTED = 3'd0;
   localparam logic [2:0] ST_FULL = 3'd1;
   localparam logic [2:0] ST_POPPED = 3'd2;
   localparam logic [2:0] ST_EMPTY = 3'd3;
   localparam logic [2:0] ST_REMOVED = 3'd4;
   localparam logic [2:0] ST_NOTFOUND = 3'd5;
   localparam logic [2:0] ST_CULLED = 3'd6;

   typedef struct packed {
      logic [15:0] id;
      logic [15:0] handle;
      logic [31:0] stamp;
   } entry_type;

   typedef struct packed {
      logic [4:0] max_pending;
      logic [7:0] age_cutoff;
   } cfg_type;

   // head + offset, offset at most QUEUE_DEPTH, folded back into the ring
   function automatic logic [PTR_W-1:0] ring_pos(input logic [PTR_W-1:0] head,
                                                 input logic [CNT_W-1:0] offs);
      logic [SUM_W-1:0] s;
      s = SUM_W'(head) + SUM_W'(offs);
      if (s >= SUM_W'(QUEUE_DEPTH)) begin
         s = s - SUM_W'(QUEUE_DEPTH);
      end
      return s[PTR_W-1:0];
   endfunction

endpackage

/* hw/rtl/prq_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module prq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

/* hw/rtl/prq_csr.sv */
`timescale 1ns / 1ps
// Configuration registers of the pending request queue.
// Depends on prq_pkg.
module prq_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          wr_en,
   input  logic [prq_pkg::CSR_IDX_W-1:0] wr_index,
   input  logic [prq_pkg::CSR_DAT_W-1:0] wr_data,
   output prq_pkg::cfg_type              cfg
);

   prq_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_pending <= 5'd16;
         cfg_ff.age_cutoff <= 8'd5;
      end else if (wr_en) begin
         case (wr_index)
            prq_pkg::CSR_MAX_PENDING: cfg_ff.max_pending <= wr_data[4:0];
            prq_pkg::CSR_AGE_CUTOFF: cfg_ff.age_cutoff <= wr_data;
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

/* hw/rtl/pending_request_queue_with_aging_core.sv */
`timescale 1ns / 1ps
// Pending request queue with aging: entries kept in a ring buffer in one RAM.
// Add/take: an add may then cull old entries at the head (check, reread each).
// Remove: scans entries for the id, then moves each entry behind the hole up a
// slot (read, then write); the RAM has one read port. One transaction at a time.
// Synchronous reset empties the queue and loads max_pending 16, age_cutoff 5.
// Depends on prq_pkg, prq_ram, prq_csr.
module pending_request_queue_with_aging_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_cmd,
   input  logic [15:0]                   req_request_id,
   input  logic [15:0]                   req_payload_handle,
   input  logic [31:0]                   req_now_time,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [2:0]                    rsp_status,
   output logic [15:0]                   rsp_out_id,
   output logic [15:0]                   rsp_out_handle,
   output logic                          rsp_last,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [prq_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [prq_pkg::CSR_DAT_W-1:0] csr_wdata
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_TAKE = 3'd1;
   localparam logic [2:0] S_CULL_CK = 3'd2;
   localparam logic [2:0] S_CULL_RD = 3'd3;
   localparam logic [2:0] S_SCAN_CK = 3'd4;
   localparam logic [2:0] S_SCAN_RD = 3'd5;
   localparam logic [2:0] S_SH_RD = 3'd6;
   localparam logic [2:0] S_SH_WR = 3'd7;

   prq_pkg::cfg_type cfg;

   logic [2:0] state_ff, state_in;
   logic [prq_pkg::PTR_W-1:0] hd_ff, hd_in;
   logic [prq_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic [prq_pkg::CNT_W-1:0] idx_ff, idx_in;
   logic [15:0] rid_ff, rid_in;
   logic [31:0] now_ff, now_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic [2:0] status_ff, status_in;
   logic [15:0] oid_ff, oid_in;
   logic [15:0] ohnd_ff, ohnd_in;
   logic last_ff, last_in;

   logic we;
   logic [prq_pkg::PTR_W-1:0] waddr, raddr;
   prq_pkg::entry_type wdata, rdata;

   logic out_free, accept, at_limit, old, match;
   logic [31:0] age;
   logic [prq_pkg::CNT_W-1:0] idx_nx;

   assign csr_ready = 1'b1;

   prq_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (csr_valid),
      .wr_index(csr_index),
      .wr_data (csr_wdata),
      .cfg     (cfg)
   );

   prq_ram #(
      .WIDTH($bits(prq_pkg::entry_type)),
      .DEPTH(prq_pkg::QUEUE_DEPTH)
   ) u_ram (
      .clock(clock),
      .we   (we),
      .waddr(waddr),
      .wdata(wdata),
      .raddr(raddr),
      .rdata(rdata)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && out_free;
   assign accept = req_valid && req_ready;
   assign at_limit = (32'(cnt_ff) >= 32'(cfg.max_pending))
                  || (cnt_ff == prq_pkg::CNT_W'(prq_pkg::QUEUE_DEPTH));
   assign age = now_ff - rdata.stamp;
   assign old = !age[31] && (age[30:0] >= 31'(cfg.age_cutoff));
   assign match = (rdata.id == rid_ff);
   assign idx_nx = idx_ff + prq_pkg::CNT_W'(1);

   always_comb begin
      state_in = state_ff;
      hd_in = hd_ff;
      cnt_in = cnt_ff;
      idx_in = idx_ff;
      rid_in = rid_ff;
      now_in = now_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      status_in = status_ff;
      oid_in = oid_ff;
      ohnd_in = ohnd_ff;
      last_in = last_ff;
      we = 1'b0;
      waddr = prq_pkg::ring_pos(hd_ff, cnt_ff);
      wdata.id = req_request_id;
      wdata.handle = req_payload_handle;
      wdata.stamp = req_now_time;
      raddr = hd_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rid_in = req_request_id;
               now_in = req_now_time;
               oid_in = 16'd0;
               ohnd_in = 16'd0;
               last_in = 1'b1;
               case (req_cmd)
                  prq_pkg::CMD_ADD: begin
                     if (cnt_ff == '0) begin
                        we = 1'b1;
                        cnt_in = prq_pkg::CNT_W'(1);
                        rsp_valid_in = 1'b1;
                        status_in = prq_pkg::ST_ACCEPTED;
                     end else if (at_limit) begin
                        rsp_valid_in = 1'b1;
                        status_in = prq_pkg::ST_FULL;
                     end else begin
                        we = 1'b1;
                        cnt_in = cnt_ff + prq_pkg::CNT_W'(1);
                        state_in = S_CULL_CK;
                     end
                  end
                  prq_pkg::CMD_TAKE: begin
                     if (cnt_ff == '0) begin
                        rsp_valid_in = 1'b1;
                        status_in = prq_pkg::ST_EMPTY;
                     end else begin
                        state_in = S_TAKE;
                     end
                  end
                  prq_pkg::CMD_REMOVE: begin
                     idx_in = '0;
                     if (cnt_ff == '0) begin
                        rsp_valid_in = 1'b1;
                        status_in = prq_pkg::ST_NOTFOUND;
                     end else begin
                        state_in = S_SCAN_CK;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_TAKE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               status_in = prq_pkg::ST_POPPED;
               oid_in = rdata.id;
               ohnd_in = rdata.handle;
               last_in = 1'b1;
               hd_in = prq_pkg::ring_pos(hd_ff, prq_pkg::CNT_W'(1));
               cnt_in = cnt_ff - prq_pkg::CNT_W'(1);
               state_in = S_IDLE;
            end
         end
         S_CULL_CK: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               ohnd_in = 16'd0;
               if ((cnt_ff > prq_pkg::CNT_W'(1)) && old) begin
                  status_in = prq_pkg::ST_CULLED;
                  oid_in = rdata.id;
                  last_in = 1'b0;
                  hd_in = prq_pkg::ring_pos(hd_ff, prq_pkg::CNT_W'(1));
                  cnt_in = cnt_ff - prq_pkg::CNT_W'(1);
                  state_in = S_CULL_RD;
               end else begin
                  status_in = prq_pkg::ST_ACCEPTED;
                  oid_in = 16'd0;
                  last_in = 1'b1;
                  state_in = S_IDLE;
               end
            end
         end
         S_CULL_RD: begin
            state_in = S_CULL_CK;
         end
         S_SCAN_CK: begin
            raddr = prq_pkg::ring_pos(hd_ff, idx_ff);
            if (match) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  status_in = prq_pkg::ST_REMOVED;
                  oid_in = rdata.id;
                  ohnd_in = rdata.handle;
                  last_in = 1'b1;
                  state_in = S_SH_RD;
               end
            end else if (idx_nx < cnt_ff) begin
               idx_in = idx_nx;
               state_in = S_SCAN_RD;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               status_in = prq_pkg::ST_NOTFOUND;
               oid_in = 16'd0;
               ohnd_in = 16'd0;
               last_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_SCAN_RD: begin
            raddr = prq_pkg::ring_pos(hd_ff, idx_ff);
            state_in = S_SCAN_CK;
         end
         S_SH_RD: begin
            if (idx_nx < cnt_ff) begin
               raddr = prq_pkg::ring_pos(hd_ff, idx_nx);
               state_in = S_SH_WR;
            end else begin
               cnt_in = cnt_ff - prq_pkg::CNT_W'(1);
               state_in = S_IDLE;
            end
         end
         S_SH_WR: begin
            we = 1'b1;
            waddr = prq_pkg::ring_pos(hd_ff, idx_ff);
            wdata = rdata;
            idx_in = idx_nx;
            state_in = S_SH_RD;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         hd_ff <= '0;
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         hd_ff <= hd_in;
         cnt_ff <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      rid_ff <= rid_in;
      now_ff <= now_in;
      status_ff <= status_in;
      oid_ff <= oid_in;
      ohnd_ff <= ohnd_in;
      last_ff <= last_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = status_ff;
   assign rsp_out_id = oid_ff;
   assign rsp_out_handle = ohnd_ff;
   assign rsp_last = last_ff;

endmodule
